[hw/rtl/trhf_pkg.sv]
// trhf_pkg: payload structs, readout codes, register indexes and the
// hysteresis band compare for the tempo readout filter.
// No dependencies.
package trhf_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_RATE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FLOOR  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_DELTA  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLEW_STEP   = 3'd4;

  // Register reset values
  localparam logic [9:0]  BAND_RATE_RST  = 10'd20;
  localparam logic [7:0]  BAND_FLOOR_RST = 8'd1;
  localparam logic [15:0] HOLD_MS_RST    = 16'd500;
  localparam logic [9:0]  JUMP_DELTA_RST = 10'd5;
  localparam logic [7:0]  SLEW_STEP_RST  = 8'd1;

  // Readout mode codes
  localparam logic [1:0] MODE_INTERNAL = 2'd0;
  localparam logic [1:0] MODE_EXTERNAL = 2'd1;
  localparam logic [1:0] MODE_LOST     = 2'd2;

  // Redraw codes
  localparam logic [1:0] REDRAW_NONE    = 2'd0;
  localparam logic [1:0] REDRAW_CHANGED = 2'd1;
  localparam logic [1:0] REDRAW_FULL    = 2'd2;

  // Half-band = max(floor, round(shown * rate / 10000))
  localparam logic [13:0] BAND_DIV   = 14'd10000;
  localparam logic [12:0] BAND_ROUND = 13'd5000;

  typedef struct packed {
    logic [12:0] internal_bpm;
    logic        external_present;
    logic [15:0] external_tenths;
    logic        lock_lost;
    logic [31:0] now_ms;
    logic        invalidate;
  } in_t;

  typedef struct packed {
    logic [15:0] shown_tenths;
    logic [1:0]  shown_mode;
    logic [1:0]  redraw_kind;
  } out_t;

  // True when half-band >= k. band_x is shown * rate + 5000, so the
  // rounded quotient reaches k exactly when band_x >= k * 10000.
  function automatic logic band_ge(input logic [26:0] band_x,
                                   input logic [7:0]  floor_val,
                                   input logic [16:0] k);
    logic [30:0] k_scaled;
    k_scaled = 31'(k) * 31'(BAND_DIV);
    return ({9'd0, floor_val} >= k) || ({4'd0, band_x} >= k_scaled);
  endfunction

endpackage

[hw/rtl/tempo_readout_hysteresis_filter.sv]
// tempo_readout_hysteresis_filter: per-sample tempo readout decision with
// hysteresis, rate limiting and slew. Depends on trhf_pkg.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------
//   in      | in  | in_valid/in_ready   | trhf_pkg::in_t (one tempo sample)
//   out     | out | out_valid/out_ready | trhf_pkg::out_t (one readout)
//   cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (reg write)
//
// Cycles: one beat in, one beat out; the result is registered and is valid
// in the cycle after its sample is taken. A new sample is taken every cycle
// while the output register drains. The readout state loop (shown value
// through the band compare back into the state) sets the per-cycle depth.
// Reset: synchronous rst clears the readout state to internal mode, value
// 0, and loads the register defaults. No clearing pass.
// Stalls: in_ready drops only while a result sits unaccepted in the output
// register; cfg_ready is always high.
module tempo_readout_hysteresis_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  trhf_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output trhf_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trhf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [trhf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic [9:0]  band_rate;
  logic [7:0]  band_floor;
  logic [15:0] hold_interval_ms;
  logic [9:0]  jump_delta;
  logic [7:0]  slew_step;

  // Readout state
  logic        shown_ok;
  logic        shown_is_external;
  logic        shown_is_lost;
  logic [15:0] shown_value;
  logic [31:0] last_update_ms;

  logic        shown_ok_next;
  logic        shown_is_external_next;
  logic        shown_is_lost_next;
  logic [15:0] shown_value_next;
  logic [31:0] last_update_ms_next;
  logic [1:0]  redraw_next;

  logic        in_fire;
  logic        cfg_fire;

  // Datapath terms
  logic        ok_eff;
  logic [16:0] ibpm_x10;
  logic [25:0] band_prod;
  logic [26:0] band_x;
  logic        tgt_up;
  logic [15:0] delta;
  logic        ge_delta;
  logic        band_wrap;
  logic        ge_wrap_low;
  logic        in_band;
  logic        small_move;
  logic [31:0] elapsed;
  logic        too_soon;
  logic        full;
  logic [15:0] ext_target;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;

  // ---- band and rate-limit terms, all from the current state ----
  assign ok_eff    = shown_ok & ~in_data.invalidate;
  assign ibpm_x10  = {1'b0, in_data.internal_bpm, 3'b000} + {3'b000, in_data.internal_bpm, 1'b0};
  assign band_prod = 26'(shown_value) * 26'(band_rate);
  assign band_x    = {1'b0, band_prod} + {14'd0, trhf_pkg::BAND_ROUND};

  assign tgt_up = in_data.external_tenths >= shown_value;
  assign delta  = tgt_up ? in_data.external_tenths - shown_value
                         : shown_value - in_data.external_tenths;

  // Upper edge wraps when shown + h passes 16 bits; the wrapped edge then
  // sits below shown, so only downward targets under it stay in band.
  assign ge_delta    = trhf_pkg::band_ge(band_x, band_floor, {1'b0, delta});
  assign band_wrap   = trhf_pkg::band_ge(band_x, band_floor,
                                         17'h10000 - {1'b0, shown_value});
  assign ge_wrap_low = trhf_pkg::band_ge(band_x, band_floor,
                                         17'h10000 - {1'b0, delta});
  assign in_band     = tgt_up ? (ge_delta & ~band_wrap)
                              : (ge_delta & (~band_wrap | ge_wrap_low));

  assign small_move = delta < {6'd0, jump_delta};
  assign elapsed    = in_data.now_ms - last_update_ms;
  assign too_soon   = elapsed < {16'd0, hold_interval_ms};

  always_comb begin
    if (!small_move) begin
      ext_target = in_data.external_tenths;
    end else if (in_data.external_tenths > shown_value) begin
      ext_target = shown_value + {8'd0, slew_step};
    end else if (shown_value > {8'd0, slew_step}) begin
      ext_target = shown_value - {8'd0, slew_step};
    end else begin
      ext_target = 16'd0;
    end
  end

  // ---- next readout state ----
  always_comb begin
    shown_ok_next          = ok_eff;
    shown_is_external_next = shown_is_external;
    shown_is_lost_next     = shown_is_lost;
    shown_value_next       = shown_value;
    last_update_ms_next    = last_update_ms;
    redraw_next            = trhf_pkg::REDRAW_NONE;
    full                   = 1'b0;

    if (in_data.lock_lost) begin
      if (!(ok_eff && shown_is_lost)) begin
        shown_ok_next          = 1'b1;
        shown_is_external_next = 1'b0;
        shown_is_lost_next     = 1'b1;
        shown_value_next       = 16'd0;
        last_update_ms_next    = 32'd0;
        redraw_next            = trhf_pkg::REDRAW_FULL;
      end
    end else if (!in_data.external_present) begin
      shown_is_lost_next = 1'b0;
      full = ~ok_eff | shown_is_lost | shown_is_external;
      if (full || shown_value != ibpm_x10[15:0]) begin
        shown_ok_next          = 1'b1;
        shown_is_external_next = 1'b0;
        shown_value_next       = ibpm_x10[15:0];
        last_update_ms_next    = 32'd0;
        redraw_next = full ? trhf_pkg::REDRAW_FULL : trhf_pkg::REDRAW_CHANGED;
      end
    end else begin
      shown_is_lost_next = 1'b0;
      full = ~ok_eff | shown_is_lost | ~shown_is_external;
      if (full) begin
        shown_ok_next          = 1'b1;
        shown_is_external_next = 1'b1;
        shown_value_next       = in_data.external_tenths;
        last_update_ms_next    = in_data.now_ms;
        redraw_next            = trhf_pkg::REDRAW_FULL;
      end else if (!in_band && !(small_move && too_soon)) begin
        // zero slew step still restamps the time but draws nothing
        shown_ok_next          = 1'b1;
        shown_is_external_next = 1'b1;
        shown_value_next       = ext_target;
        last_update_ms_next    = in_data.now_ms;
        redraw_next = (ext_target != shown_value) ? trhf_pkg::REDRAW_CHANGED
                                                  : trhf_pkg::REDRAW_NONE;
      end
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      band_rate         <= trhf_pkg::BAND_RATE_RST;
      band_floor        <= trhf_pkg::BAND_FLOOR_RST;
      hold_interval_ms  <= trhf_pkg::HOLD_MS_RST;
      jump_delta        <= trhf_pkg::JUMP_DELTA_RST;
      slew_step         <= trhf_pkg::SLEW_STEP_RST;
      shown_ok          <= 1'b0;
      shown_is_external <= 1'b0;
      shown_is_lost     <= 1'b0;
      shown_value       <= 16'd0;
      last_update_ms    <= 32'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          trhf_pkg::CFG_BAND_RATE:  band_rate        <= cfg_data[9:0];
          trhf_pkg::CFG_BAND_FLOOR: band_floor       <= cfg_data[7:0];
          trhf_pkg::CFG_HOLD_MS:    hold_interval_ms <= cfg_data;
          trhf_pkg::CFG_JUMP_DELTA: jump_delta       <= cfg_data[9:0];
          trhf_pkg::CFG_SLEW_STEP:  slew_step        <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        shown_ok          <= shown_ok_next;
        shown_is_external <= shown_is_external_next;
        shown_is_lost     <= shown_is_lost_next;
        shown_value       <= shown_value_next;
        last_update_ms    <= last_update_ms_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the state it reports
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.shown_tenths <= shown_value_next;
      out_data.shown_mode   <= shown_is_lost_next     ? trhf_pkg::MODE_LOST :
                               shown_is_external_next ? trhf_pkg::MODE_EXTERNAL :
                                                        trhf_pkg::MODE_INTERNAL;
      out_data.redraw_kind  <= redraw_next;
    end
  end

`ifndef ASSERT_OFF
  a_lost_state_clean: assert property (@(posedge clk) disable iff (rst)
    shown_is_lost |-> (shown_value == 16'd0) && !shown_is_external && shown_ok)
    else $error("sync-lost state carries a value or external flag");

  a_lost_shows_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.shown_mode == trhf_pkg::MODE_LOST)
      |-> (out_data.shown_tenths == 16'd0))
    else $error("sync-lost readout is not zero");

  a_invalidate_full: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.invalidate |=> out_data.redraw_kind == trhf_pkg::REDRAW_FULL)
    else $error("invalidated screen not fully redrawn");

  a_lost_held: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.lock_lost && !in_data.invalidate && shown_is_lost
      |=> out_data.redraw_kind == trhf_pkg::REDRAW_NONE)
    else $error("held sync-lost readout redrawn");

  a_result_follows_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && (out_data.shown_tenths == shown_value))
    else $error("result register out of step with readout state");
`endif

endmodule

[bench/tempo_readout_hysteresis_filter_test.sv]
// Self-checking bench for tempo_readout_hysteresis_filter: a scoreboard class
// predicts every readout while plain tasks drive samples and register writes.
// Depends on trhf_pkg and the block's RTL only.
module tempo_readout_hysteresis_filter_test;

  localparam int unsigned PHASES            = 6;
  localparam int unsigned SAMPLES_PER_PHASE = 250;
  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam int unsigned TENTHS_PER_BPM    = 10;
  localparam int unsigned MAX_BPM           = 6553;
  // Indexes above the last register; writes there must change nothing.
  localparam logic [trhf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO =
    trhf_pkg::CFG_SLEW_STEP + 3'd1;

  // Readout scoreboard: own copy of the registers and the readout state,
  // one expected readout queued per accepted sample.
  class readout_scoreboard;
    logic [9:0]  band_rate;
    logic [7:0]  band_floor;
    logic [15:0] hold_ms;
    logic [9:0]  jump_delta;
    logic [7:0]  slew_step;

    bit          drawn;
    bit          on_external;
    bit          on_lost;
    logic [15:0] shown;
    logic [31:0] changed_at;

    trhf_pkg::out_t due_readouts[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    redraws[3];

    function new();
      band_rate   = trhf_pkg::BAND_RATE_RST;
      band_floor  = trhf_pkg::BAND_FLOOR_RST;
      hold_ms     = trhf_pkg::HOLD_MS_RST;
      jump_delta  = trhf_pkg::JUMP_DELTA_RST;
      slew_step   = trhf_pkg::SLEW_STEP_RST;
      drawn       = 1'b0;
      on_external = 1'b0;
      on_lost     = 1'b0;
      shown       = '0;
      changed_at  = '0;
      mismatches  = 0;
      checked     = 0;
      foreach (redraws[k]) redraws[k] = 0;
    endfunction

    function void write_reg(logic [trhf_pkg::CFG_INDEX_W-1:0] idx,
                            logic [trhf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        trhf_pkg::CFG_BAND_RATE:  band_rate  = data[9:0];
        trhf_pkg::CFG_BAND_FLOOR: band_floor = data[7:0];
        trhf_pkg::CFG_HOLD_MS:    hold_ms    = data;
        trhf_pkg::CFG_JUMP_DELTA: jump_delta = data[9:0];
        trhf_pkg::CFG_SLEW_STEP:  slew_step  = data[7:0];
        default: ;
      endcase
    endfunction

    // Rounded rate share of the shown value, never below the floor.
    function logic [15:0] half_band(logic [15:0] base);
      logic [31:0] h;
      h = (32'(base) * 32'(band_rate) + 32'(trhf_pkg::BAND_ROUND))
          / 32'(trhf_pkg::BAND_DIV);
      if (h < 32'(band_floor)) h = 32'(band_floor);
      return h[15:0];
    endfunction

    function void note_sample(trhf_pkg::in_t s);
      trhf_pkg::out_t r;
      logic [15:0]    target, h, upper, lower, delta;
      logic [1:0]     kind;
      bit             was_lost, full, short_move, held;

      was_lost = on_lost;
      held     = 1'b0;
      if (s.invalidate) drawn = 1'b0;

      if (s.lock_lost) begin
        if (drawn && on_lost) begin
          kind = trhf_pkg::REDRAW_NONE;
        end else begin
          drawn       = 1'b1;
          on_external = 1'b0;
          on_lost     = 1'b1;
          shown       = '0;
          changed_at  = '0;
          kind        = trhf_pkg::REDRAW_FULL;
        end
      end else begin
        on_lost = 1'b0;
        if (!s.external_present) begin
          target = 16'(32'(s.internal_bpm) * TENTHS_PER_BPM);
          if (drawn && !was_lost && !on_external && shown == target) begin
            kind = trhf_pkg::REDRAW_NONE;
          end else begin
            full        = !drawn || was_lost || on_external;
            drawn       = 1'b1;
            on_external = 1'b0;
            shown       = target;
            changed_at  = '0;
            kind        = full ? trhf_pkg::REDRAW_FULL : trhf_pkg::REDRAW_CHANGED;
          end
        end else begin
          target = s.external_tenths;
          full   = !drawn || was_lost || !on_external;
          if (!full) begin
            h     = half_band(shown);
            upper = shown + h;                    // wraps at 16 bits
            lower = (shown > h) ? shown - h : '0; // saturates
            if (target <= upper && target >= lower) begin
              held = 1'b1;
            end else begin
              delta      = (target >= shown) ? target - shown : shown - target;
              short_move = delta < 16'(jump_delta);
              if (short_move && (s.now_ms - changed_at) < 32'(hold_ms)) begin
                held = 1'b1;
              end else if (short_move) begin
                if (target > shown) target = shown + 16'(slew_step);
                else target = (shown > 16'(slew_step)) ? shown - 16'(slew_step) : '0;
              end
            end
          end
          if (held) begin
            kind = trhf_pkg::REDRAW_NONE;
          end else begin
            kind        = full ? trhf_pkg::REDRAW_FULL :
                          (target != shown) ? trhf_pkg::REDRAW_CHANGED
                                            : trhf_pkg::REDRAW_NONE;
            drawn       = 1'b1;
            on_external = 1'b1;
            shown       = target;
            changed_at  = s.now_ms;
          end
        end
      end

      r.shown_tenths = shown;
      r.shown_mode   = on_lost ? trhf_pkg::MODE_LOST :
                       (on_external ? trhf_pkg::MODE_EXTERNAL : trhf_pkg::MODE_INTERNAL);
      r.redraw_kind  = kind;
      due_readouts.push_back(r);
    endfunction

    function void check_readout(trhf_pkg::out_t got);
      trhf_pkg::out_t want;
      if (due_readouts.size() == 0) begin
        $error("readout with no sample pending: tenths %0d mode %0d redraw %0d",
               got.shown_tenths, got.shown_mode, got.redraw_kind);
        mismatches++;
        return;
      end
      want = due_readouts.pop_front();
      checked++;
      if (want.redraw_kind < 3) redraws[want.redraw_kind]++;
      if (got.shown_tenths !== want.shown_tenths) begin
        $error("shown_tenths: expected %0d, got %0d", want.shown_tenths, got.shown_tenths);
        mismatches++;
      end
      if (got.shown_mode !== want.shown_mode) begin
        $error("shown_mode: expected %0d, got %0d", want.shown_mode, got.shown_mode);
        mismatches++;
      end
      if (got.redraw_kind !== want.redraw_kind) begin
        $error("redraw_kind: expected %0d, got %0d", want.redraw_kind, got.redraw_kind);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return due_readouts.size();
    endfunction
  endclass

  // Every input is known from time zero; rst stays high until released.
  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  trhf_pkg::in_t                    in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  trhf_pkg::out_t                   out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [trhf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [trhf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  readout_scoreboard sb;

  // Sample source state: a wandering external tempo, a held internal tempo
  // and the millisecond clock the samples are stamped with.
  logic [15:0] ext_base    = 16'd1200;
  logic [12:0] bpm_base    = 13'd120;
  logic [31:0] clock_ms    = '0;
  int unsigned burst_left  = 0;
  int unsigned settings_run = 1;
  int unsigned samples_run = 0;

  // Receiver stall pattern state
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tempo_readout_hysteresis_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Hard stop if the handshakes ever hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each beat taken at this edge, then pick the next
  // ready value. Modes rotate between always ready, toggling, mostly ready
  // and long stalls, each held for a random stretch.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_readout(out_data);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ~out_ready;
      2:       out_ready <= ($urandom_range(0, 9) < 6);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic trhf_pkg::in_t tempo_sample(input int unsigned bpm, input bit ext,
                                                 input int unsigned tenths, input bit lost,
                                                 input logic [31:0] now, input bit inval);
    trhf_pkg::in_t s;
    s.internal_bpm     = 13'(bpm);
    s.external_present = ext;
    s.external_tenths  = 16'(tenths);
    s.lock_lost        = lost;
    s.now_ms           = now;
    s.invalidate       = inval;
    return s;
  endfunction

  // Sender works in bursts; between bursts valid may drop for a random gap.
  // The beat counts once valid and ready were both high at the edge.
  task automatic send_sample(input trhf_pkg::in_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    samples_run++;
    burst_left--;
  endtask

  // Valid stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [trhf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [trhf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic load_settings(input int unsigned rate, input int unsigned floor_v,
                               input int unsigned hold, input int unsigned jump,
                               input int unsigned slew);
    write_reg(trhf_pkg::CFG_BAND_RATE,  16'(rate));
    write_reg(trhf_pkg::CFG_BAND_FLOOR, 16'(floor_v));
    write_reg(trhf_pkg::CFG_HOLD_MS,    16'(hold));
    write_reg(trhf_pkg::CFG_JUMP_DELTA, 16'(jump));
    write_reg(trhf_pkg::CFG_SLEW_STEP,  16'(slew));
    // junk to an unused index: must leave everything as is
    write_reg(CFG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // Wait out every expected readout and the output register.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random sample: mostly external tempo jittering around a slowly moving
  // base, so the band, hold and slew paths all get real traffic; the rest is
  // internal tempo, sync loss, screen clears and wild values.
  task automatic random_sample(output trhf_pkg::in_t s);
    logic [15:0] offs;
    int unsigned reach;
    reach = sb.jump_delta + 4;

    case ($urandom_range(0, 7))
      0:       clock_ms = clock_ms + $urandom_range(0, 3);
      1, 2:    clock_ms = clock_ms + $urandom_range(0, 60);
      3:       clock_ms = clock_ms + 32'(sb.hold_ms) + $urandom_range(0, 2) - 32'd1;
      4, 5:    clock_ms = clock_ms + $urandom_range(0, 2 * sb.hold_ms + 2);
      6:       clock_ms = clock_ms + $urandom_range(0, 1000);
      default: begin
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(100, 5000);
      end
    endcase

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        offs = 16'($urandom_range(0, 8));
        s.external_tenths = $urandom_range(0, 1) ? ext_base + offs : ext_base - offs;
      end
      6, 7: begin
        offs = 16'($urandom_range(0, reach));
        s.external_tenths = $urandom_range(0, 1) ? ext_base + offs : ext_base - offs;
      end
      8: s.external_tenths = 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       s.external_tenths = 16'd0;
          1:       s.external_tenths = 16'hFFFF;
          2:       s.external_tenths = 16'hFFFF - 16'($urandom_range(0, 300));
          default: s.external_tenths = 16'($urandom_range(0, 300));
        endcase
      end
    endcase
    if ($urandom_range(0, 9) < 3) ext_base = s.external_tenths;
    if ($urandom_range(0, 9) == 0) bpm_base = 13'($urandom_range(0, MAX_BPM));

    s.internal_bpm     = bpm_base;
    s.external_present = ($urandom_range(0, 99) < 70);
    s.lock_lost        = ($urandom_range(0, 99) < 4);
    s.invalidate       = ($urandom_range(0, 99) < 3);
    s.now_ms           = clock_ms;
  endtask

  initial begin
    trhf_pkg::in_t s;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values (band 20/10000, floor 1, hold 500,
    // jump 5, slew 1).
    send_sample(tempo_sample(0, 0, 0, 0, 0, 0));          // first draw: full
    send_sample(tempo_sample(0, 0, 0, 0, 0, 0));          // same internal: none
    send_sample(tempo_sample(MAX_BPM, 0, 0, 0, 0, 0));    // x10 = 65530, changed
    send_sample(tempo_sample(4095, 0, 0, 0, 0, 1));       // screen cleared: full
    send_sample(tempo_sample(120, 0, 0, 0, 0, 0));        // changed
    send_sample(tempo_sample(0, 1, 1200, 0, 1000, 0));    // to external: full
    send_sample(tempo_sample(0, 1, 1202, 0, 1100, 0));    // upper band edge: held
    send_sample(tempo_sample(0, 1, 1203, 0, 1200, 0));    // small, too soon: held
    send_sample(tempo_sample(0, 1, 1203, 0, 1600, 0));    // small, due: slew up
    send_sample(tempo_sample(0, 1, 1150, 0, 1700, 0));    // large: jump
    send_sample(tempo_sample(0, 1, 1150, 0, 1800, 1));    // cleared: full
    send_sample(tempo_sample(0, 0, 0, 1, 1900, 0));       // sync lost: full
    send_sample(tempo_sample(0, 0, 0, 1, 2000, 0));       // lost held: none
    send_sample(tempo_sample(0, 1, 500, 1, 2100, 1));     // lost + clear: full
    send_sample(tempo_sample(0, 1, 65535, 0, 32'hFFFF_FF00, 0)); // after lost: full
    send_sample(tempo_sample(0, 1, 0, 0, 32'hFFFF_FF10, 0));     // upper edge wraps
    send_sample(tempo_sample(0, 1, 2, 0, 32'hFFFF_FF20, 0));     // floor band, held
    send_sample(tempo_sample(0, 1, 2, 0, 32'h0000_0100, 0));     // wrapped 496 ms
    send_sample(tempo_sample(0, 1, 2, 0, 32'h0000_0110, 0));     // wrapped 512 ms
    send_sample(tempo_sample(0, 1, 0, 0, 32'h0000_0400, 0));     // lower edge at 0
    send_sample(tempo_sample(MAX_BPM, 0, 0, 0, 32'hFFFF_FFFF, 0)); // back internal
    send_sample(tempo_sample(0, 0, 16'hFFFF, 0, 32'hFFFF_FFFF, 0));
    send_sample(tempo_sample(MAX_BPM, 1, 65535, 0, 32'hFFFF_FFFF, 0));
    send_sample(tempo_sample(MAX_BPM, 1, 65534, 0, 32'h0000_0000, 0));

    // Random phases; each later one first loads a new register setting, block idle.
    // The first three cover both extremes of every register but band rate (0-1000).
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: load_settings(0, 0, 0, 1023, 255);
          2: load_settings(1000, 255, 65535, 1023, 0);
          3: load_settings(20, 1, 500, 0, 1);
          default: load_settings($urandom_range(0, 1000), $urandom_range(0, 255),
                                 $urandom_range(0, 2000), $urandom_range(0, 1023),
                                 $urandom_range(0, 255));
        endcase
      end
      repeat (SAMPLES_PER_PHASE) begin
        random_sample(s);
        send_sample(s);
      end
    end
    drain();

    $display("Ran %0d tempo samples under %0d register settings, %0d readouts checked.",
             samples_run, settings_run, sb.checked);
    $display("Redraws predicted: %0d none, %0d changed-only, %0d full.",
             sb.redraws[trhf_pkg::REDRAW_NONE], sb.redraws[trhf_pkg::REDRAW_CHANGED],
             sb.redraws[trhf_pkg::REDRAW_FULL]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
